[sv/flap_position_controller_defines.svh]
// Assertion macros shared by the flap position controller RTL.
// Plain text macros only; no other file dependencies.
`ifndef FLAP_POSITION_CONTROLLER_DEFINES_SVH
`define FLAP_POSITION_CONTROLLER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define FPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fpc_pkg.sv]
// Shared types and constants of the flap position controller.
// No dependencies; used by fpc_event, fpc_span and the top level.
package fpc_pkg;

    // Module geometry and command codes
    localparam int POSITION_COUNT      = 64;   // must be a power of two
    localparam int KEEP_CODE           = 0;
    localparam int CALIBRATE_CODE      = 1;
    localparam int FIRST_POSITION_CODE = 2;

    localparam int POS_W      = 6;             // positions are held modulo 64
    localparam int CODE_W     = 8;
    localparam int WIDE_W     = 10;            // holds code range and position count
    localparam int HS_W       = 16;            // half-step counts
    localparam int COUNT_LOG2 = $clog2(POSITION_COUNT);

    localparam int RESET_HALF_STEPS = 4096;

    // Event kinds on the input channel
    typedef enum logic [1:0] {
        EVT_COMMAND   = 2'd0,
        EVT_REACHED   = 2'd1,
        EVT_PERSISTED = 2'd2,
        EVT_RESTORE   = 2'd3
    } evt_kind_t;

    // Result codes
    typedef enum logic [2:0] {
        RES_ACCEPTED    = 3'd0,
        RES_IGNORED     = 3'd1,
        RES_CALIBRATED  = 3'd2,
        RES_START       = 3'd3,
        RES_NOT_COMMAND = 3'd4
    } res_code_t;

    typedef struct packed {
        logic [POS_W-1:0] current;
        logic [POS_W-1:0] target;
        logic             calibrated;
        logic             moving;
        logic             pending;
    } state_t;

    typedef struct packed {
        evt_kind_t         kind;
        logic [CODE_W-1:0] command_byte;
        logic [POS_W-1:0]  saved_pos;
        logic              stored_valid;
    } item_t;

    typedef struct packed {
        res_code_t        result_code;
        logic             reached_target;
        logic             ready_res;
        logic             is_calibrated;
        logic             is_moving;
        logic             persist_pending;
        logic [POS_W-1:0] position_now;
        logic [POS_W-1:0] position_goal;
        logic [HS_W-1:0]  steps_to_next;
    } result_t;

endpackage

[sv/flap_position_controller.sv]
// Flap position controller: one event per item, single-pass update between
// an input register and a result register. Depends on fpc_pkg, fpc_event,
// fpc_span and flap_position_controller_defines.svh.
//
// Use: the s_ channel carries events (kind in s_tuser, command byte and
// saved position in s_tdata); the m_ channel returns one result per event
// with the result code in m_tuser and flags, positions and the half-step
// count to the next position in m_tdata. The cfg channel writes
// half_steps_per_turn and is always ready; write it only while idle.
// Path: an accepted item is held in the input register, moves into the
// result register and is offered on m_ from then on.
// Throughput: one item per cycle while m_tready does not stall the result,
// with the event logic feeding back into the position and flag registers.
// Reset: aresetn low clears both positions and all flags, empties both
// registers and loads half_steps_per_turn with 4096.
// Stall: while m_tready is low the result holds; one more item is taken
// into the input register, then s_tready drops until the result leaves.
`include "flap_position_controller_defines.svh"

module flap_position_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command_byte[7:0], saved_pos[13:8],
                                   // stored_valid[14], zero[15]
    input  logic [1:0]  s_tuser,   // evt_kind[1:0]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // reached_target[0], ready_res[1],
                                   // is_calibrated[2], is_moving[3],
                                   // persist_pending[4], position_now[10:5],
                                   // position_goal[16:11], steps_to_next[32:17],
                                   // zero[39:33]
    output logic [2:0]  m_tuser,   // result_code[2:0]
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // half_steps_per_turn[15:0]
);

    logic                       in_valid_reg, in_valid_next;
    fpc_pkg::item_t             in_item_reg, in_item_next;
    logic                       out_valid_reg, out_valid_next;
    fpc_pkg::result_t           out_res_reg, out_res_next;
    fpc_pkg::state_t            st_reg, st_next;
    logic [fpc_pkg::HS_W-1:0]   spt_reg, spt_next;

    fpc_pkg::state_t            ev_state;
    fpc_pkg::res_code_t         ev_code;
    logic                       ev_reached;
    logic [fpc_pkg::HS_W-1:0]   ev_steps;

    logic                       advance;
    logic                       fire;
    logic                       s_accept;

    // Handshake control
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign fire      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    fpc_event u_event (
        .st             (st_reg),
        .item           (in_item_reg),
        .st_next        (ev_state),
        .result_code    (ev_code),
        .reached_target (ev_reached)
    );

    fpc_span u_span (
        .half_steps_per_turn (spt_reg),
        .pos                 (ev_state.current),
        .steps_to_next       (ev_steps)
    );

    // Next values of the input, state, result and config registers
    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_accept) begin
            in_valid_next             = 1'b1;
            in_item_next.kind         = fpc_pkg::evt_kind_t'(s_tuser);
            in_item_next.command_byte = s_tdata[7:0];
            in_item_next.saved_pos    = s_tdata[13:8];
            in_item_next.stored_valid = s_tdata[14];
        end

        st_next = fire ? ev_state : st_reg;

        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_res_next   = out_res_reg;
        if (fire) begin
            out_res_next.result_code     = ev_code;
            out_res_next.reached_target  = ev_reached;
            out_res_next.ready_res       = ev_state.calibrated && !ev_state.moving
                                           && !ev_state.pending;
            out_res_next.is_calibrated   = ev_state.calibrated;
            out_res_next.is_moving       = ev_state.moving;
            out_res_next.persist_pending = ev_state.pending;
            out_res_next.position_now    = ev_state.current;
            out_res_next.position_goal   = ev_state.target;
            out_res_next.steps_to_next   = ev_steps;
        end

        spt_next = (cfg_valid && cfg_ready) ? cfg_data : spt_reg;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            spt_reg       <= fpc_pkg::HS_W'(fpc_pkg::RESET_HALF_STEPS);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            spt_reg       <= spt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    // Pack the result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.result_code;
    assign m_tdata  = {7'd0,
                       out_res_reg.steps_to_next,
                       out_res_reg.position_goal,
                       out_res_reg.position_now,
                       out_res_reg.persist_pending,
                       out_res_reg.is_moving,
                       out_res_reg.is_calibrated,
                       out_res_reg.ready_res,
                       out_res_reg.reached_target};

    // Motion is only ever started on a calibrated module
    `FPC_ASSERT_SAME(a_moving_calibrated, aclk, aresetn, st_reg.moving, st_reg.calibrated, "moving while uncalibrated")
    // Any motion leaves a position to be saved
    `FPC_ASSERT_SAME(a_moving_pending, aclk, aresetn, st_reg.moving, st_reg.pending, "moving without pending save")
    // A waiting input item is held while the result side is stalled
    `FPC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "input item lost under stall")

endmodule

[sv/fpc_event.sv]
// Event decoder and next-state logic of the flap position controller.
// Depends on fpc_pkg for the state, item and result-code types.
module fpc_event (
    input  fpc_pkg::state_t    st,
    input  fpc_pkg::item_t     item,
    output fpc_pkg::state_t    st_next,
    output fpc_pkg::res_code_t result_code,
    output logic               reached_target
);

    localparam logic [fpc_pkg::WIDE_W-1:0] FIRST_W =
        fpc_pkg::WIDE_W'(fpc_pkg::FIRST_POSITION_CODE);
    localparam logic [fpc_pkg::WIDE_W-1:0] LAST_W =
        fpc_pkg::WIDE_W'(fpc_pkg::FIRST_POSITION_CODE + fpc_pkg::POSITION_COUNT - 1);
    localparam logic [fpc_pkg::WIDE_W-1:0] COUNT_W =
        fpc_pkg::WIDE_W'(fpc_pkg::POSITION_COUNT);
    localparam logic [fpc_pkg::CODE_W-1:0] KEEP_C =
        fpc_pkg::CODE_W'(fpc_pkg::KEEP_CODE);
    localparam logic [fpc_pkg::CODE_W-1:0] CAL_C =
        fpc_pkg::CODE_W'(fpc_pkg::CALIBRATE_CODE);

    logic [fpc_pkg::WIDE_W-1:0] code_w;
    logic [fpc_pkg::WIDE_W-1:0] goal_w;
    logic [fpc_pkg::WIDE_W-1:0] step_w;
    logic [fpc_pkg::POS_W-1:0]  goal;
    logic [fpc_pkg::POS_W-1:0]  advanced;
    logic                       in_range;

    // Decode the position command and the advanced position
    always_comb begin
        code_w   = fpc_pkg::WIDE_W'(item.command_byte);
        in_range = (code_w >= FIRST_W) && (code_w <= LAST_W);
        goal_w   = code_w - FIRST_W;
        goal     = goal_w[fpc_pkg::POS_W-1:0];
        step_w   = fpc_pkg::WIDE_W'(st.current) + fpc_pkg::WIDE_W'(1);
        if (step_w >= COUNT_W) begin
            step_w = '0;
        end
        advanced = step_w[fpc_pkg::POS_W-1:0];
    end

    // Apply one event to the state
    always_comb begin
        st_next        = st;
        result_code    = fpc_pkg::RES_NOT_COMMAND;
        reached_target = 1'b0;
        case (item.kind)
            fpc_pkg::EVT_COMMAND: begin
                if (item.command_byte == KEEP_C) begin
                    result_code = fpc_pkg::RES_ACCEPTED;
                end else if (item.command_byte == CAL_C) begin
                    if (st.moving) begin
                        result_code = fpc_pkg::RES_IGNORED;
                    end else begin
                        st_next.current    = '0;
                        st_next.target     = '0;
                        st_next.calibrated = 1'b1;
                        st_next.moving     = 1'b0;
                        st_next.pending    = 1'b1;
                        result_code        = fpc_pkg::RES_CALIBRATED;
                    end
                end else if (!in_range || !st.calibrated) begin
                    result_code = fpc_pkg::RES_IGNORED;
                end else begin
                    st_next.target = goal;
                    if (st.moving || (goal == st.current)) begin
                        result_code = fpc_pkg::RES_ACCEPTED;
                    end else begin
                        st_next.moving  = 1'b1;
                        st_next.pending = 1'b1;
                        result_code     = fpc_pkg::RES_START;
                    end
                end
            end
            fpc_pkg::EVT_REACHED: begin
                st_next.current = advanced;
                if (advanced == st.target) begin
                    st_next.moving = 1'b0;
                    reached_target = 1'b1;
                end
            end
            fpc_pkg::EVT_PERSISTED: begin
                if (!st.moving) begin
                    st_next.pending = 1'b0;
                end
            end
            fpc_pkg::EVT_RESTORE: begin
                st_next.current    = item.saved_pos;
                st_next.target     = item.saved_pos;
                st_next.calibrated = item.stored_valid;
                st_next.moving     = 1'b0;
                st_next.pending    = 1'b0;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

[sv/fpc_span.sv]
// Half-step count from one position to the next, spreading the remainder
// of the per-turn count evenly over the drum. Depends on fpc_pkg.
module fpc_span (
    input  logic [fpc_pkg::HS_W-1:0]  half_steps_per_turn,
    input  logic [fpc_pkg::POS_W-1:0] pos,
    output logic [fpc_pkg::HS_W-1:0]  steps_to_next
);

    localparam int PROD_W = fpc_pkg::COUNT_LOG2 + fpc_pkg::POS_W + 1;

    logic [fpc_pkg::HS_W-1:0]       base;
    logic [fpc_pkg::COUNT_LOG2-1:0] rem;
    logic [PROD_W-1:0]              prod_here;
    logic [PROD_W-1:0]              prod_there;
    logic [PROD_W-1:0]              extra_here;
    logic [PROD_W-1:0]              extra_there;

    // Split the turn into whole steps per position and a remainder
    always_comb begin
        base        = half_steps_per_turn >> fpc_pkg::COUNT_LOG2;
        rem         = half_steps_per_turn[fpc_pkg::COUNT_LOG2-1:0];
        prod_here   = PROD_W'(rem) * PROD_W'(pos);
        prod_there  = PROD_W'(rem) * (PROD_W'(pos) + PROD_W'(1));
        extra_here  = prod_here >> fpc_pkg::COUNT_LOG2;
        extra_there = prod_there >> fpc_pkg::COUNT_LOG2;
        steps_to_next = base + fpc_pkg::HS_W'(extra_there) - fpc_pkg::HS_W'(extra_here);
    end

endmodule
